// ----- src/rgb_to_i420_converter_unit_assert.svh -----
// Assertion macros shared by the converter RTL.
// Each macro expands to one labeled concurrent assertion with an async reset guard.
`ifndef RGB_TO_I420_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_I420_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RGB2I420_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RGB2I420_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rgb2i420_pkg.sv -----
// Shared types and constants of the RGB to I420 converter.
// No dependencies; every other RTL file but the generic RAM imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rgb2i420_pkg;

    localparam int WIDTH_LIMIT   = 4096;
    localparam int PAIR_DEPTH    = WIDTH_LIMIT / 2;
    localparam int PAIR_AW       = $clog2(PAIR_DEPTH);
    localparam int COORD_W       = 12;
    localparam int CFG_DATA_W    = 13;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int PAIR_W        = 27;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0]         luma;
        logic               chroma_valid;
        logic [7:0]         cb;
        logic [7:0]         cr;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               frame_end;
    } result_t;

    // Horizontal pair sums of one pixel pair.
    typedef struct packed {
        logic [8:0] sum_r;
        logic [8:0] sum_g;
        logic [8:0] sum_b;
    } pair_t;

    // Beat leaving the front end: luma done, pair sums formed, line store read issued.
    typedef struct packed {
        logic               valid;
        logic [7:0]         luma;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               frame_end;
        logic               chroma;
        pair_t              pair;
    } stage1_t;

endpackage

`default_nettype wire

// ----- src/rgb2i420_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rgb2i420_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/rgb2i420_front.sv -----
// Front end: size registers, raster counters, luma, pair sums and line store access.
// Depends on rgb2i420_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_i420_converter_unit_assert.svh"

module rgb2i420_front
    import rgb2i420_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  pixel_t                pixel,
    input  logic                  s2_ready,
    output stage1_t               s1,
    output logic                  ram_wr_en,
    output logic                  ram_rd_en,
    output logic [PAIR_AW-1:0]    ram_addr,
    output pair_t                 ram_wr_data
);

    // Drops the low four bits, clamps to 32..limit and returns size minus one.
    function automatic logic [COORD_W-1:0] size_last(input logic [CFG_DATA_W-1:0] v,
                                                     input logic [CFG_DATA_W-1:0] limit);
        logic [CFG_DATA_W-1:0] m;
        m = {v[CFG_DATA_W-1:4], 4'b0000};
        if (m < CFG_DATA_W'(32))
        begin
            m = CFG_DATA_W'(32);
        end
        else if (m > limit)
        begin
            m = limit;
        end
        return COORD_W'(m - CFG_DATA_W'(1));
    endfunction

    logic [COORD_W-1:0] width_last_reg, width_last_next;
    logic [COORD_W-1:0] height_last_reg, height_last_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    pixel_t             held_reg, held_next;
    stage1_t            s1_reg, s1_next;

    logic        s1_ready;
    logic        accept;
    logic        last_col;
    logic        last_row;
    logic [15:0] luma_acc;
    pair_t       pair;

    assign s1_ready    = !s1_reg.valid || s2_ready;
    assign pixel_stall = !s1_ready;
    assign accept      = pixel_valid && s1_ready;
    assign last_col    = col_reg >= width_last_reg;
    assign last_row    = row_reg >= height_last_reg;

    assign luma_acc = 16'd66 * {8'd0, pixel.red} + 16'd129 * {8'd0, pixel.green}
                    + 16'd25 * {8'd0, pixel.blue};

    assign pair.sum_r = {1'b0, held_reg.red} + {1'b0, pixel.red};
    assign pair.sum_g = {1'b0, held_reg.green} + {1'b0, pixel.green};
    assign pair.sum_b = {1'b0, held_reg.blue} + {1'b0, pixel.blue};

    // Even rows store the pair, odd rows fetch it; the two never touch one entry
    // in the same cycle, since a row lies between them.
    assign ram_wr_en   = accept && col_reg[0] && !row_reg[0];
    assign ram_rd_en   = accept && col_reg[0] && row_reg[0];
    assign ram_addr    = col_reg[PAIR_AW:1];
    assign ram_wr_data = pair;

    always_comb
    begin
        width_last_next  = width_last_reg;
        height_last_next = height_last_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        held_next        = held_reg;
        s1_next          = s1_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_last_next  = size_last(cfg_data,
                                                               CFG_DATA_W'(WIDTH_LIMIT));
                CFG_FRAME_HEIGHT: height_last_next = size_last(cfg_data,
                                                               CFG_DATA_W'(HEIGHT_LIMIT));
                default: ;
            endcase
        end

        if (accept)
        begin
            if (!col_reg[0])
            begin
                held_next = pixel;
            end
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + COORD_W'(1);
            end
            else
            begin
                col_next = col_reg + COORD_W'(1);
            end
        end

        if (s1_ready)
        begin
            s1_next.valid     = pixel_valid;
            s1_next.luma      = 8'd16 + luma_acc[15:8];
            s1_next.column    = col_reg;
            s1_next.row       = row_reg;
            s1_next.frame_end = last_col && last_row;
            s1_next.chroma    = col_reg[0] && row_reg[0];
            s1_next.pair      = pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg  <= COORD_W'(RESET_WIDTH - 1);
            height_last_reg <= COORD_W'(RESET_HEIGHT - 1);
            col_reg         <= '0;
            row_reg         <= '0;
            held_reg        <= '0;
            s1_reg          <= '0;
        end
        else
        begin
            width_last_reg  <= width_last_next;
            height_last_reg <= height_last_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            held_reg        <= held_next;
            s1_reg          <= s1_next;
        end
    end

    assign s1 = s1_reg;

    `RGB2I420_ASSERT_IMPL(a_ram_one_access, clk, rst_n, ram_wr_en, !ram_rd_en,
        "line store read and write in one cycle")
    `RGB2I420_ASSERT_NEXT(a_row_wrap, clk, rst_n, accept && last_col, col_reg == '0,
        "column count did not wrap at row end")
    `RGB2I420_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_reg.valid && !s2_ready, $stable(s1_reg),
        "front stage changed while held")

endmodule

`default_nettype wire

// ----- src/rgb2i420_chroma.sv -----
// Back end: 2x2 averaging with the fetched pair sums, chroma matrix and output register.
// Depends on rgb2i420_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_i420_converter_unit_assert.svh"

module rgb2i420_chroma
    import rgb2i420_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  stage1_t s1,
    input  pair_t   ram_rd_data,
    output logic    s2_ready,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    typedef struct packed {
        logic               valid;
        logic [7:0]         luma;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               frame_end;
        logic               chroma;
        logic [7:0]         avg_r;
        logic [7:0]         avg_g;
        logic [7:0]         avg_b;
    } stage2_t;

    stage2_t s2_reg, s2_next;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    logic        out_ready;
    logic [9:0]  tot_r;
    logic [9:0]  tot_g;
    logic [9:0]  tot_b;
    logic [16:0] ext_r;
    logic [16:0] ext_g;
    logic [16:0] ext_b;
    logic [16:0] cb_acc;
    logic [16:0] cr_acc;

    assign out_ready = !result_valid_reg || !result_stall;
    assign s2_ready  = !s2_reg.valid || out_ready;

    // The line store read data stays put until the next fetch, and the next
    // fetch only happens on the edge that moves this beat on.
    assign tot_r = {1'b0, s1.pair.sum_r} + {1'b0, ram_rd_data.sum_r};
    assign tot_g = {1'b0, s1.pair.sum_g} + {1'b0, ram_rd_data.sum_g};
    assign tot_b = {1'b0, s1.pair.sum_b} + {1'b0, ram_rd_data.sum_b};

    assign ext_r = {9'd0, s2_reg.avg_r};
    assign ext_g = {9'd0, s2_reg.avg_g};
    assign ext_b = {9'd0, s2_reg.avg_b};

    // Both sums stay within a 16-bit signed range, so adding 128 after the
    // floor shift amounts to flipping the sign bit of the upper byte.
    assign cb_acc = 17'd112 * ext_b - 17'd38 * ext_r - 17'd74 * ext_g;
    assign cr_acc = 17'd112 * ext_r - 17'd94 * ext_g - 17'd18 * ext_b;

    always_comb
    begin
        s2_next           = s2_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (s2_ready)
        begin
            s2_next.valid     = s1.valid;
            s2_next.luma      = s1.luma;
            s2_next.column    = s1.column;
            s2_next.row       = s1.row;
            s2_next.frame_end = s1.frame_end;
            s2_next.chroma    = s1.chroma;
            s2_next.avg_r     = tot_r[9:2];
            s2_next.avg_g     = tot_g[9:2];
            s2_next.avg_b     = tot_b[9:2];
        end

        if (out_ready)
        begin
            result_valid_next        = s2_reg.valid;
            result_next.luma         = s2_reg.luma;
            result_next.chroma_valid = s2_reg.chroma;
            result_next.cb           = s2_reg.chroma ? {~cb_acc[15], cb_acc[14:8]} : 8'd0;
            result_next.cr           = s2_reg.chroma ? {~cr_acc[15], cr_acc[14:8]} : 8'd0;
            result_next.column       = s2_reg.column;
            result_next.row          = s2_reg.row;
            result_next.frame_end    = s2_reg.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg           <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            s2_reg           <= s2_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `RGB2I420_ASSERT_IMPL(a_chroma_position, clk, rst_n,
        result_valid_reg && result_reg.chroma_valid,
        result_reg.column[0] && result_reg.row[0], "chroma given off a block corner")
    `RGB2I420_ASSERT_IMPL(a_chroma_zero, clk, rst_n,
        result_valid_reg && !result_reg.chroma_valid,
        result_reg.cb == 8'd0 && result_reg.cr == 8'd0, "chroma nonzero without a block")
    `RGB2I420_ASSERT_NEXT(a_s2_hold, clk, rst_n, s2_reg.valid && !out_ready, $stable(s2_reg),
        "middle stage changed while held")

endmodule

`default_nettype wire

// ----- src/rgb_to_i420_converter_unit.sv -----
// Top level of the RGB to I420 converter: front end, line store RAM and chroma back end.
// Depends on rgb2i420_pkg, rgb2i420_ram, rgb2i420_front and rgb2i420_chroma.
//
//   channel   direction  handshake                    payload
//   pixel     in         pixel_valid / pixel_stall    pixel_t  (red, green, blue)
//   result    out        result_valid / result_stall  result_t (luma .. frame_end)
//   cfg       in         cfg_write                    cfg_index, cfg_data
//
// One pixel is taken per clock while pixel_stall is low; each passes the s1, s2 and result registers.
// The line store is a single RAM with one write and one read port; even rows
// write pair sums, odd rows read them back one row later.
// Reset clears counters and stages and loads the 640x480 default size; the line store needs no clearing pass.
// A stall on the result side holds the stages; bubbles inside still fill.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_i420_converter_unit
    import rgb2i420_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  pixel_t                pixel,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result
);

    stage1_t            s1;
    logic               s2_ready;
    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [PAIR_AW-1:0] ram_addr;
    pair_t              ram_wr_data;
    pair_t              ram_rd_data;

    rgb2i420_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .s2_ready    (s2_ready),
        .s1          (s1),
        .ram_wr_en   (ram_wr_en),
        .ram_rd_en   (ram_rd_en),
        .ram_addr    (ram_addr),
        .ram_wr_data (ram_wr_data)
    );

    rgb2i420_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (PAIR_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_addr),
        .rd_data (ram_rd_data)
    );

    rgb2i420_chroma u_chroma (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1           (s1),
        .ram_rd_data  (ram_rd_data),
        .s2_ready     (s2_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- test/rgb_to_i420_converter_unit_checker.sv -----
// Checker for the RGB to I420 converter: watches the config port and both channels,
// predicts each result beat in raster order and compares it field by field.
// Depends on rgb2i420_pkg for the port types and size constants.
`timescale 1ns / 1ps

module rgb_to_i420_converter_unit_checker
    import rgb2i420_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pixel_valid,
    input  logic                  pixel_stall,
    input  pixel_t                pixel,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  result_t               result,
    output int                    mismatches,
    output int                    samples_due,
    output int                    chroma_blocks,
    output int                    frame_ends,
    output logic [COORD_W-1:0]    next_column,
    output logic [COORD_W-1:0]    next_row
);

    localparam int MIN_SIZE = 32;

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    int                    col_pos;
    int                    row_pos;
    pixel_t                left_pixel;
    pair_t                 even_row_pairs [PAIR_DEPTH];
    result_t               expected_samples [$];
    result_t               oldest;

    // The low four bits are dropped before the size is clamped.
    function automatic int usable_size(logic [CFG_DATA_W-1:0] raw, int ceiling);
        int v;
        v = int'(raw) & 'h1FF0;
        if (v < MIN_SIZE)
            v = MIN_SIZE;
        if (v > ceiling)
            v = ceiling;
        return v;
    endfunction

    function automatic result_t convert_pixel(pixel_t px);
        result_t res;
        pair_t   across;
        pair_t   above;
        int      w;
        int      h;
        int      ar;
        int      ag;
        int      ab;
        bit      last_col;
        bit      last_row;
        w = usable_size(width_reg, WIDTH_LIMIT);
        h = usable_size(height_reg, HEIGHT_LIMIT);
        last_col = col_pos >= w - 1;
        last_row = row_pos >= h - 1;
        res = '0;
        res.luma = 8'(16 + ((66 * int'(px.red) + 129 * int'(px.green)
                             + 25 * int'(px.blue)) >> 8));
        res.column = COORD_W'(col_pos);
        res.row = COORD_W'(row_pos);
        res.frame_end = last_col && last_row;
        if (col_pos % 2 == 0)
        begin
            left_pixel = px;
        end
        else
        begin
            across.sum_r = 9'(left_pixel.red) + 9'(px.red);
            across.sum_g = 9'(left_pixel.green) + 9'(px.green);
            across.sum_b = 9'(left_pixel.blue) + 9'(px.blue);
            if (row_pos % 2 == 0)
            begin
                even_row_pairs[col_pos / 2] = across;
            end
            else
            begin
                // Average of the 2x2 block, then a floor shift with the 128 offset folded in.
                above = even_row_pairs[col_pos / 2];
                ar = (int'(across.sum_r) + int'(above.sum_r)) >> 2;
                ag = (int'(across.sum_g) + int'(above.sum_g)) >> 2;
                ab = (int'(across.sum_b) + int'(above.sum_b)) >> 2;
                res.chroma_valid = 1'b1;
                res.cb = 8'((-38 * ar - 74 * ag + 112 * ab + 32768) >> 8);
                res.cr = 8'((112 * ar - 94 * ag - 18 * ab + 32768) >> 8);
            end
        end
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
        end
        return res;
    endfunction

    task automatic flag_field(string field, logic [COORD_W-1:0] want,
                              logic [COORD_W-1:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = CFG_DATA_W'(RESET_WIDTH);
            height_reg = CFG_DATA_W'(RESET_HEIGHT);
            col_pos = 0;
            row_pos = 0;
            left_pixel = '0;
            expected_samples.delete();
            mismatches = 0;
            chroma_blocks = 0;
            frame_ends = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: result beat, expected none, actual %h", $time, result);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_samples[0];
                    expected_samples.delete(0);
                    if (result.luma !== oldest.luma)
                        flag_field("luma", oldest.luma, result.luma);
                    if (result.chroma_valid !== oldest.chroma_valid)
                        flag_field("chroma_valid", oldest.chroma_valid, result.chroma_valid);
                    if (result.cb !== oldest.cb)
                        flag_field("cb", oldest.cb, result.cb);
                    if (result.cr !== oldest.cr)
                        flag_field("cr", oldest.cr, result.cr);
                    if (result.column !== oldest.column)
                        flag_field("column", oldest.column, result.column);
                    if (result.row !== oldest.row)
                        flag_field("row", oldest.row, result.row);
                    if (result.frame_end !== oldest.frame_end)
                        flag_field("frame_end", oldest.frame_end, result.frame_end);
                    if (oldest.chroma_valid)
                        chroma_blocks++;
                    if (oldest.frame_end)
                        frame_ends++;
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (pixel_valid && !pixel_stall)
                expected_samples.insert(expected_samples.size(), convert_pixel(pixel));
        end
        samples_due = expected_samples.size();
        next_column = COORD_W'(col_pos);
        next_row = COORD_W'(row_pos);
    end

endmodule

// ----- test/tb_rgb_to_i420_converter_unit.sv -----
// Testbench top for rgb_to_i420_converter_unit: clock, reset, pixel and config stimulus,
// result back-pressure and the verdict. Depends on rgb2i420_pkg and the checker module.
`timescale 1ns / 1ps

module tb_rgb_to_i420_converter_unit;
    import rgb2i420_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 150;
    localparam int PIPE_SETTLE  = 6;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    cfg_index_t            cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_stall;
    pixel_t                pixel = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b1;
    result_t               result;

    int                    mismatches;
    int                    samples_due;
    int                    chroma_blocks;
    int                    frame_ends;
    logic [COORD_W-1:0]    next_column;
    logic [COORD_W-1:0]    next_row;

    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    bit                    hold_request = 1'b0;
    int                    hold_left = 0;
    int                    quiet_cycles = 0;
    int                    pixels_sent = 0;

    rgb_to_i420_converter_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    rgb_to_i420_converter_unit_checker conversion_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_valid   (pixel_valid),
        .pixel_stall   (pixel_stall),
        .pixel         (pixel),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .mismatches    (mismatches),
        .samples_due   (samples_due),
        .chroma_blocks (chroma_blocks),
        .frame_ends    (frame_ends),
        .next_column   (next_column),
        .next_row      (next_row)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side back-pressure; a long hold lets the block fill up and stall its input.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (pixel_valid && !pixel_stall)
            || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("rgb_to_i420_converter_unit regression: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic pixel_t random_pixel();
        pixel_t px;
        px = 24'($urandom);
        if ($urandom_range(7) == 0)
        begin
            px.red = $urandom_range(1) ? 8'hFF : 8'h00;
            px.green = $urandom_range(1) ? 8'hFF : 8'h00;
            px.blue = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return px;
    endfunction

    // Corner k of directed block blk: 0 and 1 on the even row, 2 and 3 below them.
    function automatic pixel_t corner_pixel(int blk, int k);
        pixel_t q [4];
        case (blk)
            1:       q = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
            2:       q = '{24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000};
            3:       q = '{24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00};
            4:       q = '{24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF};
            5:       q = '{24'hFFFF00, 24'hFFFF00, 24'hFFFF00, 24'hFFFF00};
            6:       q = '{24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF};
            7:       q = '{24'hFF00FF, 24'hFF00FF, 24'hFF00FF, 24'hFF00FF};
            8:       q = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000};
            9:       q = '{24'hFF0000, 24'h0000FF, 24'hFF0000, 24'h0000FF};
            10:      q = '{24'h0000FF, 24'h0000FF, 24'h000000, 24'h0000FF};
            // Block sums below four must floor to zero.
            11:      q = '{24'h000000, 24'h010101, 24'h010101, 24'h010101};
            12:      q = '{24'hFE0180, 24'h01FE7F, 24'h807F01, 24'h7F80FE};
            13:      q = '{24'h808080, 24'h808080, 24'h808080, 24'h808080};
            14:      q = '{24'h0000FF, 24'h0000FF, 24'hFFFF00, 24'hFFFF00};
            15:      q = '{24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555};
            default: q = '{24'h000000, 24'h000000, 24'h000000, 24'h000000};
        endcase
        return q[k];
    endfunction

    task automatic send_pixel(input pixel_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel <= px;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        pixels_sent++;
        if (pixels_sent == HOLD_AT)
            hold_request = 1'b1;
        @(negedge clk);
    endtask

    task automatic send_pixels(input int count);
        repeat (count)
            send_pixel(random_pixel());
    endtask

    // Waits until every result is out, then writes both size registers.
    task automatic write_sizes(input logic [CFG_DATA_W-1:0] w,
                               input logic [CFG_DATA_W-1:0] h);
        pixel_valid <= 1'b0;
        while (samples_due != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE)
            @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data <= h;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Sizes change only at the start of an even row with the block drained, so an odd
    // row never reads a pair entry that its own width did not write.
    task automatic resize(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        while (next_column != '0 || next_row[0])
            send_pixel(random_pixel());
        write_sizes(w, h);
    endtask

    initial
    begin
        int                    base_w;
        logic [CFG_DATA_W-1:0] h_raw;
        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 29;
        recv_idle_pct <= 63;
        // Stray low width bits are ignored (32 wide); the height saturates at 4096.
        resize(13'd47, 13'h1FFF);
        for (int k = 0; k < 4; k += 2)
        begin
            for (int b = 0; b < 16; b++)
            begin
                send_pixel(corner_pixel(b, k));
                send_pixel(corner_pixel(b, k + 1));
            end
        end
        send_pixels(32 * 4);

        send_idle_pct = 63;
        recv_idle_pct <= 29;
        // The width saturates at 4096; shrinking it partway through an even row ends
        // that row on the next pixel, and the odd row below reads pairs stored wide.
        resize(13'h1FFF, 13'd0);
        send_pixels(40);
        write_sizes(13'd32, 13'd32);
        send_pixels(1 + 32);

        for (int seg = 0; seg < 4; seg++)
        begin
            if (seg == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            base_w = 16 * $urandom_range(2, 4);
            h_raw = CFG_DATA_W'(16 * $urandom_range(2, 6));
            if ($urandom_range(3) == 0)
                h_raw = $urandom_range(1) ? 13'h1FFF : 13'h0000;
            resize(CFG_DATA_W'(base_w) | CFG_DATA_W'($urandom_range(15)), h_raw);
            send_pixels(base_w * 2);
        end

        pixel_valid <= 1'b0;
        while (samples_due != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE)
            @(negedge clk);
        $display("Sent %0d pixels at row widths of 32 to 4096, including a mid-row shrink.",
                 pixels_sent);
        $display("Results with chroma: %0d, results at a frame end: %0d.",
                 chroma_blocks, frame_ends);
        if (mismatches == 0 && samples_due == 0)
            $display("rgb_to_i420_converter_unit regression: pass");
        else
            $display("rgb_to_i420_converter_unit regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/rgb2i420_pkg.sv
src/rgb2i420_ram.sv
src/rgb2i420_front.sv
src/rgb2i420_chroma.sv
src/rgb_to_i420_converter_unit.sv
test/rgb_to_i420_converter_unit_checker.sv
test/tb_rgb_to_i420_converter_unit.sv
